>>> rtl/qrm_pkg.sv
`default_nettype none
package qrm_pkg;

    localparam int QW    = 16;  // quaternion parts and matrix entries
    localparam int QONE  = 16384;
    localparam int QBITS = 15;  // quotient bits, enough for 0..16384
    localparam int PW    = 32;  // 16x16 signed products
    localparam int NW    = 33;  // n = sum of squares, below 2^33
    localparam int NUMW  = 35;  // signed numerators
    localparam int MW    = 33;  // numerator magnitude, never above n
    localparam int DW    = NW + 1;           // divisor 2n
    localparam int AW    = DW + QBITS - 1;   // dividend and remainder
    localparam int LANES = 9;

    // Matrix entries in row-major order; the diagonal is lanes 0, 4 and 8.
    localparam logic [LANES-1:0] DIAG_MASK = 9'b100010001;

    typedef logic signed [QW-1:0]   t_q;
    typedef logic signed [PW-1:0]   t_prod;
    typedef logic signed [NUMW-1:0] t_num;

    typedef struct packed {
        t_prod ww;
        t_prod xx;
        t_prod yy;
        t_prod zz;
        t_prod xy;
        t_prod zw;
        t_prod xz;
        t_prod yw;
        t_prod yz;
        t_prod xw;
    } t_prods;

    typedef struct packed {
        logic [NW-1:0]               n;
        logic [LANES-1:0][NUMW-1:0]  num;
    } t_sums;

    typedef struct packed {
        logic [DW-1:0]               den;
        logic                        zero;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0][AW-1:0]    rem;
        logic [LANES-1:0][QBITS-1:0] quo;
    } t_div;

    typedef logic [LANES-1:0][QW-1:0] t_mat;

endpackage
`default_nettype wire

>>> rtl/qrm_mul.sv
`default_nettype none
module qrm_mul (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  qrm_pkg::t_q    i_w,
    input  qrm_pkg::t_q    i_x,
    input  qrm_pkg::t_q    i_y,
    input  qrm_pkg::t_q    i_z,
    output logic           o_valid,
    input  logic           i_ready,
    output qrm_pkg::t_prods o_prods
);
    import qrm_pkg::*;

    logic   r_valid;
    t_prods r_prods;
    t_prods n_prods;

    assign o_ready = !r_valid || i_ready;

    always_comb begin
        n_prods.ww = t_prod'(i_w) * t_prod'(i_w);
        n_prods.xx = t_prod'(i_x) * t_prod'(i_x);
        n_prods.yy = t_prod'(i_y) * t_prod'(i_y);
        n_prods.zz = t_prod'(i_z) * t_prod'(i_z);
        n_prods.xy = t_prod'(i_x) * t_prod'(i_y);
        n_prods.zw = t_prod'(i_z) * t_prod'(i_w);
        n_prods.xz = t_prod'(i_x) * t_prod'(i_z);
        n_prods.yw = t_prod'(i_y) * t_prod'(i_w);
        n_prods.yz = t_prod'(i_y) * t_prod'(i_z);
        n_prods.xw = t_prod'(i_x) * t_prod'(i_w);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_prods <= n_prods;
        end
    end

    assign o_valid = r_valid;
    assign o_prods = r_prods;

endmodule
`default_nettype wire

>>> rtl/qrm_sums.sv
`default_nettype none
module qrm_sums (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  qrm_pkg::t_prods i_prods,
    output logic            o_valid,
    input  logic            i_ready,
    output qrm_pkg::t_div   o_div
);
    import qrm_pkg::*;

    logic  r_valid_a;
    logic  r_valid_b;
    logic  ready_a;
    logic  ready_b;
    t_sums r_sums;
    t_sums n_sums;
    t_div  r_div;
    t_div  n_div;

    assign ready_b = !r_valid_b || i_ready;
    assign ready_a = !r_valid_a || ready_b;
    assign o_ready = ready_a;

    // First stage: the sum of squares and the nine signed numerators.
    always_comb begin
        n_sums.n = NW'(i_prods.ww) + NW'(i_prods.xx) + NW'(i_prods.yy) + NW'(i_prods.zz);
        n_sums.num[0] = t_num'(i_prods.ww) + t_num'(i_prods.xx)
                      - t_num'(i_prods.yy) - t_num'(i_prods.zz);
        n_sums.num[1] = (t_num'(i_prods.xy) - t_num'(i_prods.zw)) <<< 1;
        n_sums.num[2] = (t_num'(i_prods.xz) + t_num'(i_prods.yw)) <<< 1;
        n_sums.num[3] = (t_num'(i_prods.xy) + t_num'(i_prods.zw)) <<< 1;
        n_sums.num[4] = t_num'(i_prods.ww) - t_num'(i_prods.xx)
                      + t_num'(i_prods.yy) - t_num'(i_prods.zz);
        n_sums.num[5] = (t_num'(i_prods.yz) - t_num'(i_prods.xw)) <<< 1;
        n_sums.num[6] = (t_num'(i_prods.xz) - t_num'(i_prods.yw)) <<< 1;
        n_sums.num[7] = (t_num'(i_prods.yz) + t_num'(i_prods.xw)) <<< 1;
        n_sums.num[8] = t_num'(i_prods.ww) - t_num'(i_prods.xx)
                      - t_num'(i_prods.yy) + t_num'(i_prods.zz);
    end

    // Second stage: magnitude and dividend 2^15*|num| + n over divisor 2n,
    // which folds round-half-away into a plain floor division.
    always_comb begin
        t_num          num_s;
        logic [MW-1:0] mag;
        n_div.den  = {r_sums.n, 1'b0};
        n_div.zero = (r_sums.n == '0);
        for (int i = 0; i < LANES; i++) begin
            num_s        = $signed(r_sums.num[i]);
            n_div.neg[i] = num_s[NUMW-1];
            mag          = num_s[NUMW-1] ? MW'(-num_s) : MW'(num_s);
            n_div.rem[i] = (AW'(mag) << QBITS) + AW'(r_sums.n);
            n_div.quo[i] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_a <= 1'b0;
            r_valid_b <= 1'b0;
        end else begin
            if (ready_a) begin
                r_valid_a <= i_valid;
            end
            if (ready_b) begin
                r_valid_b <= r_valid_a;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_a && i_valid) begin
            r_sums <= n_sums;
        end
        if (ready_b && r_valid_a) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid_b;
    assign o_div   = r_div;

endmodule
`default_nettype wire

>>> rtl/qrm_div_stage.sv
`default_nettype none
module qrm_div_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  qrm_pkg::t_div i_div,
    output logic          o_valid,
    input  logic          i_ready,
    output qrm_pkg::t_div o_div
);
    import qrm_pkg::*;

    logic r_valid;
    t_div r_div;
    t_div n_div;

    assign o_ready = !r_valid || i_ready;

    // One quotient bit per lane. The remainder shifts left each stage, so the
    // divisor is always compared at the weight of the top quotient bit.
    always_comb begin
        logic [AW-1:0] dsh;
        logic          take;
        dsh   = {i_div.den, {(QBITS-1){1'b0}}};
        n_div = i_div;
        for (int i = 0; i < LANES; i++) begin
            take         = (i_div.rem[i] >= dsh);
            n_div.rem[i] = (take ? (i_div.rem[i] - dsh) : i_div.rem[i]) << 1;
            n_div.quo[i] = {i_div.quo[i][QBITS-2:0], take};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_div <= n_div;
        end
    end

    assign o_valid = r_valid;
    assign o_div   = r_div;

endmodule
`default_nettype wire

>>> rtl/qrm_out.sv
`default_nettype none
module qrm_out (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_ready,
    input  qrm_pkg::t_div i_div,
    output logic          o_valid,
    input  logic          i_ready,
    output qrm_pkg::t_mat o_mat
);
    import qrm_pkg::*;

    logic r_valid;
    t_mat r_mat;
    t_mat n_mat;

    assign o_ready = !r_valid || i_ready;

    // A zero quaternion has no direction and maps to the identity.
    always_comb begin
        logic [QBITS-1:0] q;
        for (int i = 0; i < LANES; i++) begin
            q = (i_div.quo[i] > QBITS'(QONE)) ? QBITS'(QONE) : i_div.quo[i];
            if (i_div.zero) begin
                n_mat[i] = DIAG_MASK[i] ? QW'(QONE) : '0;
            end else if (i_div.neg[i]) begin
                n_mat[i] = -t_q'(q);
            end else begin
                n_mat[i] = t_q'(q);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_mat <= n_mat;
        end
    end

    assign o_valid = r_valid;
    assign o_mat   = r_mat;

endmodule
`default_nettype wire

>>> rtl/quaternion_to_rotation_matrix.sv
`default_nettype none
// Converts a raw, possibly unnormalized quaternion (w,x,y,z) into the nine
// entries of its 3x3 rotation matrix in Q1.14, rounded to nearest with ties
// away from zero; a zero quaternion yields the identity. The block is a
// 19-stage pipeline: one multiply stage, two stages that form the norm and
// the numerators, fifteen restoring-division stages that each produce one
// quotient bit for all nine entries, and the output register. A request is
// accepted every cycle while the output side keeps ready high; each stage
// stalls only while it holds data that the next stage cannot take, so
// bubbles are squeezed out under stall.
module quaternion_to_rotation_matrix (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  qrm_pkg::t_q i_quat_w,
    input  qrm_pkg::t_q i_quat_x,
    input  qrm_pkg::t_q i_quat_y,
    input  qrm_pkg::t_q i_quat_z,
    output logic        o_valid,
    input  logic        i_ready,
    output qrm_pkg::t_q o_r00,
    output qrm_pkg::t_q o_r01,
    output qrm_pkg::t_q o_r02,
    output qrm_pkg::t_q o_r10,
    output qrm_pkg::t_q o_r11,
    output qrm_pkg::t_q o_r12,
    output qrm_pkg::t_q o_r20,
    output qrm_pkg::t_q o_r21,
    output qrm_pkg::t_q o_r22
);
    import qrm_pkg::*;

    logic         mul_valid;
    logic         mul_ready;
    t_prods       mul_prods;
    t_div         div_data  [QBITS+1];
    logic [QBITS:0] div_valid;
    logic [QBITS:0] div_ready;
    t_mat         mat;

    qrm_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_w     (i_quat_w),
        .i_x     (i_quat_x),
        .i_y     (i_quat_y),
        .i_z     (i_quat_z),
        .o_valid (mul_valid),
        .i_ready (mul_ready),
        .o_prods (mul_prods)
    );

    qrm_sums u_sums (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (mul_valid),
        .o_ready (mul_ready),
        .i_prods (mul_prods),
        .o_valid (div_valid[0]),
        .i_ready (div_ready[0]),
        .o_div   (div_data[0])
    );

    for (genvar k = 0; k < QBITS; k++) begin : g_div
        qrm_div_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (div_valid[k]),
            .o_ready (div_ready[k]),
            .i_div   (div_data[k]),
            .o_valid (div_valid[k+1]),
            .i_ready (div_ready[k+1]),
            .o_div   (div_data[k+1])
        );
    end

    qrm_out u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid[QBITS]),
        .o_ready (div_ready[QBITS]),
        .i_div   (div_data[QBITS]),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_mat   (mat)
    );

    assign o_r00 = mat[0];
    assign o_r01 = mat[1];
    assign o_r02 = mat[2];
    assign o_r10 = mat[3];
    assign o_r11 = mat[4];
    assign o_r12 = mat[5];
    assign o_r20 = mat[6];
    assign o_r21 = mat[7];
    assign o_r22 = mat[8];

endmodule
`default_nettype wire

>>> rtl/qrm_checker.sv
`default_nettype none
module qrm_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        o_ready,
    input  qrm_pkg::t_q i_quat_w,
    input  qrm_pkg::t_q i_quat_x,
    input  qrm_pkg::t_q i_quat_y,
    input  qrm_pkg::t_q i_quat_z,
    input  logic        o_valid,
    input  logic        i_ready,
    input  qrm_pkg::t_q o_r00,
    input  qrm_pkg::t_q o_r01,
    input  qrm_pkg::t_q o_r02,
    input  qrm_pkg::t_q o_r10,
    input  qrm_pkg::t_q o_r11,
    input  qrm_pkg::t_q o_r12,
    input  qrm_pkg::t_q o_r20,
    input  qrm_pkg::t_q o_r21,
    input  qrm_pkg::t_q o_r22
);
    import qrm_pkg::*;

    logic              in_range;
    logic signed [QW+1:0] trace;

    assign in_range =
        ($signed(o_r00) >= -QONE) && ($signed(o_r00) <= QONE) &&
        ($signed(o_r01) >= -QONE) && ($signed(o_r01) <= QONE) &&
        ($signed(o_r02) >= -QONE) && ($signed(o_r02) <= QONE) &&
        ($signed(o_r10) >= -QONE) && ($signed(o_r10) <= QONE) &&
        ($signed(o_r11) >= -QONE) && ($signed(o_r11) <= QONE) &&
        ($signed(o_r12) >= -QONE) && ($signed(o_r12) <= QONE) &&
        ($signed(o_r20) >= -QONE) && ($signed(o_r20) <= QONE) &&
        ($signed(o_r21) >= -QONE) && ($signed(o_r21) <= QONE) &&
        ($signed(o_r22) >= -QONE) && ($signed(o_r22) <= QONE);

    // The trace of a rotation is 4w^2/n - 1, so it never falls below minus
    // one beyond rounding of the three diagonal entries.
    assign trace = (QW+2)'(o_r00) + (QW+2)'(o_r11) + (QW+2)'(o_r22);

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_r00) && $stable(o_r11)
                                  && $stable(o_r22) && $stable(o_r01)))
        else $error("stalled result changed");

    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> in_range)
        else $error("matrix entry outside -1..1");

    a_trace: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (trace >= -(QONE + 2)))
        else $error("matrix trace below -1");

endmodule

bind quaternion_to_rotation_matrix qrm_checker u_qrm_checker (.*);
`default_nettype wire

>>> test/tb_quaternion_to_rotation_matrix.sv
`default_nettype none
module tb_quaternion_to_rotation_matrix;

    import qrm_pkg::*;

    typedef struct packed {
        t_q w;
        t_q x;
        t_q y;
        t_q z;
    } t_quat_req;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      i_valid = 1'b0;
    logic      i_ready = 1'b0;
    t_quat_req on_wire = '0;
    logic      o_ready;
    logic      o_valid;
    t_q        o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22;

    t_quat_req quat_backlog[$];
    t_mat      matrix_due[$];
    int        planned_total = 0;
    int        accepted_total = 0;
    int        mismatches = 0;

    quaternion_to_rotation_matrix uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_quat_w (on_wire.w),
        .i_quat_x (on_wire.x),
        .i_quat_y (on_wire.y),
        .i_quat_z (on_wire.z),
        .o_valid  (o_valid),
        .i_ready  (i_ready),
        .o_r00    (o_r00),
        .o_r01    (o_r01),
        .o_r02    (o_r02),
        .o_r10    (o_r10),
        .o_r11    (o_r11),
        .o_r12    (o_r12),
        .o_r20    (o_r20),
        .o_r21    (o_r21),
        .o_r22    (o_r22)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // One matrix entry: round(QONE * num / n), ties away from zero, clamped to +-QONE.
    function automatic t_q q14_ratio(longint num, longint n);
        longint mag;
        longint q;
        mag = (num < 0) ? -num : num;
        q = (2 * mag * QONE + n) / (2 * n);
        if (q > QONE) begin
            q = QONE;
        end
        return (num < 0) ? t_q'(-q) : t_q'(q);
    endfunction

    function automatic t_mat rotation_of(t_quat_req qr);
        longint w, x, y, z;
        longint ww, xx, yy, zz, n;
        t_mat   m;
        w = qr.w;
        x = qr.x;
        y = qr.y;
        z = qr.z;
        ww = w * w;
        xx = x * x;
        yy = y * y;
        zz = z * z;
        n = ww + xx + yy + zz;
        m = '0;
        if (n == 0) begin
            // A zero quaternion stays unnormalized and maps to the identity.
            m[0] = QW'(QONE);
            m[4] = QW'(QONE);
            m[8] = QW'(QONE);
        end else begin
            m[0] = q14_ratio(ww + xx - yy - zz, n);
            m[1] = q14_ratio(2 * (x * y - z * w), n);
            m[2] = q14_ratio(2 * (x * z + y * w), n);
            m[3] = q14_ratio(2 * (x * y + z * w), n);
            m[4] = q14_ratio(ww - xx + yy - zz, n);
            m[5] = q14_ratio(2 * (y * z - x * w), n);
            m[6] = q14_ratio(2 * (x * z - y * w), n);
            m[7] = q14_ratio(2 * (y * z + x * w), n);
            m[8] = q14_ratio(ww - xx - yy + zz, n);
        end
        return m;
    endfunction

    task automatic add_quat(int w, int x, int y, int z);
        t_quat_req qr;
        qr = '{t_q'(w), t_q'(x), t_q'(y), t_q'(z)};
        quat_backlog.insert(quat_backlog.size(), qr);
        planned_total++;
    endtask

    function automatic int small_part();
        return int'($urandom_range(0, 8)) - 4;
    endfunction

    function automatic int pow2_part();
        int p;
        p = 1 << $urandom_range(0, 14);
        return $urandom_range(0, 1) ? -p : p;
    endfunction

    // Sender: bursts of requests separated by idle gaps.
    int send_burst = 0;
    int send_gap = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                matrix_due.insert(matrix_due.size(), rotation_of(on_wire));
                accepted_total++;
            end
            if (!i_valid || o_ready) begin
                if (send_gap > 0 || quat_backlog.size() == 0) begin
                    i_valid <= 1'b0;
                    if (send_gap > 0) begin
                        send_gap--;
                    end
                end else begin
                    on_wire <= quat_backlog.pop_front();
                    i_valid <= 1'b1;
                    if (send_burst <= 1) begin
                        send_burst = $urandom_range(1, 40);
                        send_gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        send_burst--;
                    end
                end
            end
        end
    end

    // Receiver: stall pattern picks a new random mode whenever the low six bits of rx_phase wrap to zero.
    int unsigned rx_phase = 0;
    int unsigned stall_mode = 0;
    t_mat        want;
    t_q          got[LANES];
    string       entry_name[LANES] = '{"r00", "r01", "r02", "r10", "r11", "r12",
                                       "r20", "r21", "r22"};

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            rx_phase++;
            if (rx_phase[5:0] == 0) begin
                stall_mode = $urandom_range(0, 3);
            end
            case (stall_mode)
                0: begin
                    i_ready <= 1'b1;
                end
                1: begin
                    i_ready <= (rx_phase % 7) > 2;
                end
                2: begin
                    i_ready <= $urandom_range(0, 3) != 0;
                end
                default: begin
                    i_ready <= rx_phase[3:0] < 2;
                end
            endcase

            if (o_valid && i_ready) begin
                if (matrix_due.size() == 0) begin
                    $error("matrix delivered with no request outstanding");
                    mismatches++;
                end else begin
                    want = matrix_due.pop_front();
                    got = '{o_r00, o_r01, o_r02, o_r10, o_r11, o_r12, o_r20, o_r21, o_r22};
                    for (int i = 0; i < LANES; i++) begin
                        if (got[i] !== want[i]) begin
                            mismatches++;
                            $error("%s expected %0d got %0d", entry_name[i],
                                   $signed(want[i]), $signed(got[i]));
                        end
                    end
                end
            end
        end
    end

    initial begin
        int pick;
        int big;

        add_quat(0, 0, 0, 0);
        add_quat(1, 0, 0, 0);
        add_quat(-1, 0, 0, 0);
        add_quat(32767, 0, 0, 0);
        add_quat(0, -32768, 0, 0);
        add_quat(0, 0, 32767, 0);
        add_quat(0, 0, 0, -32768);
        add_quat(-32768, -32768, -32768, -32768);
        add_quat(32767, 32767, 32767, 32767);
        add_quat(-32768, 32767, -32768, 32767);
        add_quat(32767, -32768, 32767, -32768);
        add_quat(1, 1, 1, 1);
        add_quat(1, 2, 3, 4);
        add_quat(0, 1, 1, 0);
        add_quat(3, 0, 0, 4);
        add_quat(1, 32767, 0, 0);
        add_quat(-32768, 1, -1, 1);
        add_quat(0, 0, 0, 1);
        add_quat(12345, -23456, 7, -30000);
        add_quat(-1, -1, 0, 0);

        repeat (550) begin
            pick = $urandom_range(0, 9);
            if (pick <= 4) begin
                add_quat($urandom, $urandom, $urandom, $urandom);
            end else if (pick <= 6) begin
                add_quat(small_part(), small_part(), small_part(), small_part());
            end else if (pick == 7) begin
                // One part dominates; the rest are tiny, so entries sit near +-1 and 0.
                big = $urandom_range(0, 3);
                add_quat(big == 0 ? int'($urandom) : small_part(),
                         big == 1 ? int'($urandom) : small_part(),
                         big == 2 ? int'($urandom) : small_part(),
                         big == 3 ? int'($urandom) : small_part());
            end else if (pick == 8) begin
                add_quat($urandom_range(0, 1) ? int'($urandom) : 0,
                         $urandom_range(0, 1) ? int'($urandom) : 0,
                         $urandom_range(0, 1) ? int'($urandom) : 0,
                         $urandom_range(0, 1) ? int'($urandom) : 0);
            end else begin
                add_quat(pow2_part(), pow2_part(), pow2_part(), pow2_part());
            end
        end

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_total < planned_total) @(posedge i_clk);
        while (matrix_due.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
`default_nettype wire
